// ===== src/dlsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dlsw_pkg;

    localparam int FRAME_BITS = 49;
    localparam logic [5:0] LAST_BIT_CNT = 6'(FRAME_BITS - 1);

    localparam logic [2:0] WRITE_ID    = 3'b101;
    localparam logic [7:0] MARK_PRESET = 8'h30;
    localparam logic [7:0] MARK_ACTUAL = 8'h20;
    localparam logic [7:0] POINT_SEG   = 8'h01;
    localparam logic [15:0] TEMP_MAX   = 16'd9999;

    localparam logic CMD_NUMBER = 1'b0;
    localparam logic CMD_TEMP   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  addr;
        logic        mark;
        logic [15:0] rem;
        logic [3:0]  d4;
        logic [3:0]  d3;
        logic [3:0]  d2;
        logic [3:0]  d1;
    } dlsw_item_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rem;
    } dlsw_split_t;

    typedef struct packed {
        logic                    valid;
        logic [FRAME_BITS-1:0]   bits;
    } dlsw_frame_t;

    // Take one decimal digit of weight unit off v; v is below ten units.
    function automatic dlsw_split_t digit_split(input logic [15:0] v,
                                                input logic [16:0] unit);
        dlsw_split_t r;
        logic [3:0]  d;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if ({1'b0, v} >= 17'(k) * unit) begin
                d = 4'(k);
            end
        end
        r.digit = d;
        r.rem   = v - 16'({13'd0, d} * unit);
        return r;
    endfunction

    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'hbe;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h7c;
            4'd3:    g = 8'h5e;
            4'd4:    g = 8'hc6;
            4'd5:    g = 8'hda;
            4'd6:    g = 8'hfa;
            4'd7:    g = 8'h0e;
            4'd8:    g = 8'hfe;
            4'd9:    g = 8'hde;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== src/dlsw_digit_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlsw_digit_pipe
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               enable,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_cmd,
    input  wire logic [5:0]         in_addr,
    input  wire logic [15:0]        in_value,
    input  wire logic               in_mark,
    output dlsw_pkg::dlsw_frame_t   frame,
    input  wire logic               frame_ready
);

    logic                    v_reg [0:3];
    dlsw_pkg::dlsw_item_t    st_reg [0:3];
    dlsw_pkg::dlsw_item_t    st_next [0:3];
    logic                    fv_reg;
    logic [dlsw_pkg::FRAME_BITS-1:0] fb_reg;
    logic [dlsw_pkg::FRAME_BITS-1:0] fb_next;
    logic                    adv [0:4];
    logic [15:0]             sat_value;
    dlsw_pkg::dlsw_split_t   sp0;
    dlsw_pkg::dlsw_split_t   sp1;
    dlsw_pkg::dlsw_split_t   sp2;
    dlsw_pkg::dlsw_split_t   sp3;
    logic [7:0]              b0;
    logic [7:0]              b1;
    logic [7:0]              b2;
    logic [7:0]              b3;
    logic [7:0]              b4;

    // A stage moves on when it is empty or its successor moves on.
    always_comb
    begin
        adv[4] = !fv_reg || frame_ready;
        for (int i = 3; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_comb
    begin
        // Stage 1: saturate in temperature mode, take the ten-thousands digit.
        sat_value = in_value;
        if (in_cmd == dlsw_pkg::CMD_TEMP && in_value > dlsw_pkg::TEMP_MAX) begin
            sat_value = dlsw_pkg::TEMP_MAX;
        end
        sp0 = dlsw_pkg::digit_split(sat_value, 17'd10000);
        st_next[0]      = '0;
        st_next[0].cmd  = in_cmd;
        st_next[0].addr = in_addr;
        st_next[0].mark = in_mark;
        st_next[0].rem  = sp0.rem;
        st_next[0].d4   = sp0.digit;

        // Stages 2 to 4: thousands, hundreds, then tens with units left over.
        sp1 = dlsw_pkg::digit_split(st_reg[0].rem, 17'd1000);
        st_next[1]     = st_reg[0];
        st_next[1].rem = sp1.rem;
        st_next[1].d3  = sp1.digit;

        sp2 = dlsw_pkg::digit_split(st_reg[1].rem, 17'd100);
        st_next[2]     = st_reg[1];
        st_next[2].rem = sp2.rem;
        st_next[2].d2  = sp2.digit;

        sp3 = dlsw_pkg::digit_split(st_reg[2].rem, 17'd10);
        st_next[3]     = st_reg[2];
        st_next[3].rem = sp3.rem;
        st_next[3].d1  = sp3.digit;
    end

    // Stage 5: map digits to segment bytes and build the frame.
    always_comb
    begin
        if (st_reg[3].cmd == dlsw_pkg::CMD_TEMP) begin
            b0 = dlsw_pkg::glyph(st_reg[3].d3);
            b1 = dlsw_pkg::glyph(st_reg[3].d2) | dlsw_pkg::POINT_SEG;
            b2 = dlsw_pkg::glyph(st_reg[3].d1);
            b3 = dlsw_pkg::glyph(st_reg[3].rem[3:0]);
            b4 = st_reg[3].mark ? dlsw_pkg::MARK_PRESET : dlsw_pkg::MARK_ACTUAL;
        end else begin
            b0 = dlsw_pkg::glyph(st_reg[3].d4);
            b1 = dlsw_pkg::glyph(st_reg[3].d3);
            b2 = dlsw_pkg::glyph(st_reg[3].d2);
            b3 = dlsw_pkg::glyph(st_reg[3].d1);
            b4 = dlsw_pkg::glyph(st_reg[3].rem[3:0]);
        end
        fb_next = {dlsw_pkg::WRITE_ID, st_reg[3].addr, b0, b1, b2, b3, b4};
    end

    // Valid bits: drop requests at the entry while the display is off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++) begin
                v_reg[i] <= 1'b0;
            end
            fv_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid && enable;
            end
            for (int i = 1; i < 4; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            if (adv[4]) begin
                fv_reg <= v_reg[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++) begin
            if (adv[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
        if (adv[4]) begin
            fb_reg <= fb_next;
        end
    end

    assign frame.valid = fv_reg;
    assign frame.bits  = fb_reg;

endmodule

`default_nettype wire

// ===== src/decimal_lcd_segment_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decimal LCD segment writer.
// s_axis carries one display request per transfer: tdata holds ram_address,
// value and preset_mark; tuser holds cmd (0 number, 1 temperature).
// m_axis carries the serial write frame one bit per transfer, MSB first:
// write ID, 6-bit RAM address, five segment bytes, 49 transfers in all,
// with tlast on the final bit. cfg_valid/cfg_data sets display_enabled;
// write it only while no frame is pending. While it is 0, requests are
// taken and dropped without output.
// Path: a request passes four digit stages and one glyph/frame stage,
// then loads into the serializer, which sends one bit per cycle while
// m_axis_tready is high; requests are taken no faster than frames leave,
// and the pipeline holds up to five further requests meanwhile.
// Reset clears all valid bits, serializer busy/counter and display_enabled.
// When the receiver stalls, the current bit holds on m_axis and the
// pipeline behind it fills and then deasserts s_axis_tready; nothing is
// lost or repeated.

module decimal_lcd_segment_writer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [5:0] ram_address, [21:6] value, [22] preset_mark, [23] zero
    input  wire logic [23:0] s_axis_tdata,
    // [0] cmd
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] serial_bit, [7:1] zero
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    logic                  enabled_reg;
    dlsw_pkg::dlsw_frame_t frame;
    logic                  frame_ready;
    logic                  busy_reg;
    logic                  busy_next;
    logic [5:0]            cnt_reg;
    logic [5:0]            cnt_next;
    logic [dlsw_pkg::FRAME_BITS-1:0] sh_reg;
    logic [dlsw_pkg::FRAME_BITS-1:0] sh_next;
    logic                  last_bit;
    logic                  out_xfer;

    // Configuration register: always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enabled_reg <= 1'b0;
        end else if (cfg_valid) begin
            enabled_reg <= cfg_data;
        end
    end

    dlsw_digit_pipe u_pipe
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (enabled_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_addr     (s_axis_tdata[5:0]),
        .in_value    (s_axis_tdata[21:6]),
        .in_mark     (s_axis_tdata[22]),
        .frame       (frame),
        .frame_ready (frame_ready)
    );

    // Serializer: shift register plus bit counter; load the next frame
    // on the same edge the last bit of the current one transfers.
    assign last_bit    = (cnt_reg == dlsw_pkg::LAST_BIT_CNT);
    assign out_xfer    = busy_reg && m_axis_tready;
    assign frame_ready = !busy_reg || (out_xfer && last_bit);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        if (frame_ready && frame.valid) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            sh_next   = frame.bits;
        end else if (out_xfer) begin
            if (last_bit) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 6'd1;
                sh_next  = {sh_reg[dlsw_pkg::FRAME_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {7'd0, sh_reg[dlsw_pkg::FRAME_BITS-1]};
    assign m_axis_tlast  = last_bit;

    // A frame never breaks off before its last bit.
    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("frame ended before its last bit");

    // Every frame opens with the leading one of the write ID.
    a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 6'd0) |-> m_axis_tdata[0])
        else $error("frame does not start with the write ID");

    // An idle serializer lets the whole pipeline move.
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> s_axis_tready)
        else $error("input stalled while the serializer is idle");

endmodule

`default_nettype wire
